FILE: sv/lhfc_pkg.sv
// ----------------------------------------------------------------------------
// lhfc_pkg: shared types and constants
// Controller/datapath command and status structs, state codes, register
// indexes and fixed arithmetic constants of the light/humidity controller.
// ----------------------------------------------------------------------------
package lhfc_pkg;

  // Control loop state, as reported on out_state_code
  typedef enum logic [2:0] {
    MD_INIT       = 3'd0,
    MD_CHECK      = 3'd1,
    MD_DAYLIGHT   = 3'd2,
    MD_DAYHUM     = 3'd3,
    MD_HUMON      = 3'd4,
    MD_NIGHTLIGHT = 3'd5,
    MD_NIGHTHUM   = 3'd6,
    MD_WAIT       = 3'd7
  } lhfc_mode_t;

  // Sequencer states
  typedef enum logic [1:0] {
    CT_IDLE   = 2'd0,
    CT_EVAL   = 2'd1,
    CT_DIV    = 2'd2,
    CT_COMMIT = 2'd3
  } lhfc_ctl_t;

  // Configuration register indexes
  localparam logic [2:0] CFG_DAY_THRESHOLD   = 3'd0;
  localparam logic [2:0] CFG_LIGHT_MIN       = 3'd1;
  localparam logic [2:0] CFG_LIGHT_MAX       = 3'd2;
  localparam logic [2:0] CFG_HUMIDITY_MIN    = 3'd3;
  localparam logic [2:0] CFG_HUMIDIFY_MS     = 3'd4;
  localparam logic [2:0] CFG_CHECK_INTERVAL  = 3'd5;
  localparam logic [2:0] CFG_NIGHT_LEVEL     = 3'd6;
  localparam logic [2:0] CFG_NIGHT_LEVEL_ALT = 3'd7;

  // Register reset values
  localparam logic [9:0]  RST_DAY_THRESHOLD   = 10'd400;
  localparam logic [9:0]  RST_LIGHT_MIN       = 10'd300;
  localparam logic [9:0]  RST_LIGHT_MAX       = 10'd700;
  localparam logic [9:0]  RST_HUMIDITY_MIN    = 10'd400;
  localparam logic [31:0] RST_HUMIDIFY_MS     = 32'd5000;
  localparam logic [31:0] RST_CHECK_INTERVAL  = 32'd10000;
  localparam logic [7:0]  RST_NIGHT_LEVEL     = 8'd120;
  localparam logic [7:0]  RST_NIGHT_LEVEL_ALT = 8'd200;

  // Linear map constants
  localparam logic [9:0]  SENSOR_FULL = 10'd1023;
  localparam logic [7:0]  LEVEL_FULL  = 8'd255;
  localparam logic [7:0]  BRIGHT_BASE = 8'd80;
  localparam logic [7:0]  MAP_SLOPE   = LEVEL_FULL - BRIGHT_BASE;  // 175

  // Divider geometry: 10-bit sample times 8-bit slope over a 10-bit span
  localparam int DIVIDEND_W = 18;
  localparam int DIVISOR_W  = 10;
  localparam int DIV_CNT_W  = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIVIDEND_W - 1);

  typedef struct packed {
    logic capture;    // latch the input transaction
    logic div_start;  // launch the map division
    logic commit;     // apply the step and load the result register
  } lhfc_cmd_t;

  typedef struct packed {
    logic need_div;   // daylight step with a nonzero map
    logic div_done;   // quotient ready
  } lhfc_sts_t;

endpackage

FILE: sv/lhfc_div.sv
// ----------------------------------------------------------------------------
// lhfc_div: restoring divider
// One quotient bit per cycle; the quotient is DIVIDEND_W bits wide.
// ----------------------------------------------------------------------------
module lhfc_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [lhfc_pkg::DIVIDEND_W-1:0]  dividend,
  input  logic [lhfc_pkg::DIVISOR_W-1:0]   divisor,
  output logic [lhfc_pkg::DIVIDEND_W-1:0]  quotient,
  output logic                             done
);

  logic [lhfc_pkg::DIVISOR_W-1:0]   rem_r, rem_nxt;
  logic [lhfc_pkg::DIVIDEND_W-1:0]  quo_r, quo_nxt;
  logic [lhfc_pkg::DIVISOR_W-1:0]   den_r;
  logic [lhfc_pkg::DIV_CNT_W-1:0]   cnt_r;
  logic                             busy_r;
  logic                             done_r;
  logic [lhfc_pkg::DIVISOR_W:0]     trial;
  logic [lhfc_pkg::DIVISOR_W:0]     trial_sub;
  logic                             fits;

  always_comb begin
    trial     = {rem_r, quo_r[lhfc_pkg::DIVIDEND_W-1]};
    trial_sub = trial - {1'b0, den_r};
    fits      = (trial >= {1'b0, den_r});
    rem_nxt   = fits ? trial_sub[lhfc_pkg::DIVISOR_W-1:0]
                     : trial[lhfc_pkg::DIVISOR_W-1:0];
    quo_nxt   = {quo_r[lhfc_pkg::DIVIDEND_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == lhfc_pkg::DIV_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

FILE: sv/lhfc_ctrl.sv
// ----------------------------------------------------------------------------
// lhfc_ctrl: transaction sequencer
// Accepts one transaction, runs the divider when the step needs it, then
// commits into the output register once that register is free.
// ----------------------------------------------------------------------------
module lhfc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  lhfc_pkg::lhfc_sts_t sts,
  output lhfc_pkg::lhfc_cmd_t cmd
);

  lhfc_pkg::lhfc_ctl_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;

  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lhfc_pkg::CT_IDLE: begin
        if (in_valid) state_nxt = lhfc_pkg::CT_EVAL;
      end
      lhfc_pkg::CT_EVAL: begin
        state_nxt = sts.need_div ? lhfc_pkg::CT_DIV : lhfc_pkg::CT_COMMIT;
      end
      lhfc_pkg::CT_DIV: begin
        if (sts.div_done) state_nxt = lhfc_pkg::CT_COMMIT;
      end
      lhfc_pkg::CT_COMMIT: begin
        if (out_free) state_nxt = lhfc_pkg::CT_IDLE;
      end
      default: state_nxt = lhfc_pkg::CT_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      lhfc_pkg::CT_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      lhfc_pkg::CT_EVAL: begin
        cmd.div_start = sts.need_div;
      end
      lhfc_pkg::CT_DIV: begin
        cmd = '0;
      end
      lhfc_pkg::CT_COMMIT: begin
        cmd.commit = out_free;
      end
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit)           out_valid_nxt = 1'b1;
    else if (!out_stall)      out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lhfc_pkg::CT_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: sv/lhfc_dp.sv
// ----------------------------------------------------------------------------
// lhfc_dp: control loop datapath
// Configuration registers, captured samples, loop state, level registers,
// the map operand setup with its divider, and the result register.
// ----------------------------------------------------------------------------
module lhfc_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_wdata,
  input  logic [31:0]         in_now_ms,
  input  logic [9:0]          in_light_inside,
  input  logic [9:0]          in_light_outside,
  input  logic [9:0]          in_humidity_sample,
  input  logic                in_alt_button,
  input  lhfc_pkg::lhfc_cmd_t cmd,
  output lhfc_pkg::lhfc_sts_t sts,
  output logic [7:0]          out_window_pwm,
  output logic [7:0]          out_lamp_pwm,
  output logic [7:0]          out_humidifier_pwm,
  output logic [2:0]          out_state_code
);

  // configuration
  logic [9:0]  day_threshold_r, light_min_r, light_max_r, humidity_min_r;
  logic [31:0] humidify_ms_r, check_interval_r;
  logic [7:0]  night_level_r, night_level_alt_r;

  // captured transaction
  logic [31:0] now_r;
  logic [9:0]  inside_r, outside_r, humid_r;
  logic        alt_r;

  // loop state
  lhfc_pkg::lhfc_mode_t mode_r, mode_nxt;
  logic [31:0] entry_r, entry_nxt;
  logic [7:0]  window_r, window_nxt;
  logic [7:0]  lamp_r, lamp_nxt;
  logic [7:0]  humid_lvl_r, humid_lvl_nxt;

  // result register
  logic [7:0]  res_window_r, res_lamp_r, res_humid_r;
  logic [2:0]  res_state_r;

  // map operands
  logic                                  bright, dark;
  logic [9:0]                            map_diff;
  logic [lhfc_pkg::DIVIDEND_W-1:0]       map_num;
  logic [lhfc_pkg::DIVISOR_W-1:0]        map_den;
  logic [lhfc_pkg::DIVIDEND_W-1:0]       quotient;
  logic                                  div_done;
  logic [31:0]                           elapsed;
  logic [7:0]                            night_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_threshold_r   <= lhfc_pkg::RST_DAY_THRESHOLD;
      light_min_r       <= lhfc_pkg::RST_LIGHT_MIN;
      light_max_r       <= lhfc_pkg::RST_LIGHT_MAX;
      humidity_min_r    <= lhfc_pkg::RST_HUMIDITY_MIN;
      humidify_ms_r     <= lhfc_pkg::RST_HUMIDIFY_MS;
      check_interval_r  <= lhfc_pkg::RST_CHECK_INTERVAL;
      night_level_r     <= lhfc_pkg::RST_NIGHT_LEVEL;
      night_level_alt_r <= lhfc_pkg::RST_NIGHT_LEVEL_ALT;
    end else if (cfg_we) begin
      case (cfg_index)
        lhfc_pkg::CFG_DAY_THRESHOLD:   day_threshold_r   <= cfg_wdata[9:0];
        lhfc_pkg::CFG_LIGHT_MIN:       light_min_r       <= cfg_wdata[9:0];
        lhfc_pkg::CFG_LIGHT_MAX:       light_max_r       <= cfg_wdata[9:0];
        lhfc_pkg::CFG_HUMIDITY_MIN:    humidity_min_r    <= cfg_wdata[9:0];
        lhfc_pkg::CFG_HUMIDIFY_MS:     humidify_ms_r     <= cfg_wdata;
        lhfc_pkg::CFG_CHECK_INTERVAL:  check_interval_r  <= cfg_wdata;
        lhfc_pkg::CFG_NIGHT_LEVEL:     night_level_r     <= cfg_wdata[7:0];
        lhfc_pkg::CFG_NIGHT_LEVEL_ALT: night_level_alt_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      now_r     <= in_now_ms;
      inside_r  <= in_light_inside;
      outside_r <= in_light_outside;
      humid_r   <= in_humidity_sample;
      alt_r     <= in_alt_button;
    end
  end

  // Bright test wins when both hold (light_min above light_max)
  assign bright   = inside_r > light_max_r;
  assign dark     = inside_r < light_min_r;
  assign map_diff = bright ? (inside_r - light_max_r) : inside_r;
  assign map_num  = lhfc_pkg::DIVIDEND_W'(map_diff) *
                    lhfc_pkg::DIVIDEND_W'(lhfc_pkg::MAP_SLOPE);
  assign map_den  = bright ? (lhfc_pkg::SENSOR_FULL - light_max_r) : light_min_r;

  assign sts.need_div = (mode_r == lhfc_pkg::MD_DAYLIGHT) && (bright || dark);
  assign sts.div_done = div_done;

  lhfc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (map_num),
    .divisor  (map_den),
    .quotient (quotient),
    .done     (div_done)
  );

  assign elapsed   = now_r - entry_r;  // wraps mod 2^32
  assign night_sel = alt_r ? night_level_alt_r : night_level_r;

  always_comb begin
    mode_nxt      = mode_r;
    entry_nxt     = entry_r;
    window_nxt    = window_r;
    lamp_nxt      = lamp_r;
    humid_lvl_nxt = humid_lvl_r;
    case (mode_r)
      lhfc_pkg::MD_INIT: begin
        mode_nxt  = lhfc_pkg::MD_CHECK;
        entry_nxt = now_r;
      end
      lhfc_pkg::MD_CHECK: begin
        mode_nxt  = (outside_r > day_threshold_r) ? lhfc_pkg::MD_DAYLIGHT
                                                  : lhfc_pkg::MD_NIGHTLIGHT;
        entry_nxt = now_r;
      end
      lhfc_pkg::MD_DAYLIGHT: begin
        // quotient stays within the slope, so the low byte is exact
        if (bright) begin
          window_nxt = lhfc_pkg::BRIGHT_BASE + quotient[7:0];
          lamp_nxt   = '0;
        end else if (dark) begin
          lamp_nxt   = lhfc_pkg::LEVEL_FULL - quotient[7:0];
          window_nxt = '0;
        end else begin
          window_nxt = '0;
          lamp_nxt   = '0;
        end
        mode_nxt  = lhfc_pkg::MD_DAYHUM;
        entry_nxt = now_r;
      end
      lhfc_pkg::MD_DAYHUM: begin
        if (humid_r < humidity_min_r) begin
          humid_lvl_nxt = lhfc_pkg::LEVEL_FULL;
          mode_nxt      = lhfc_pkg::MD_HUMON;
        end else begin
          mode_nxt      = lhfc_pkg::MD_WAIT;
        end
        entry_nxt = now_r;
      end
      lhfc_pkg::MD_HUMON: begin
        if (elapsed >= humidify_ms_r) begin
          humid_lvl_nxt = '0;
          mode_nxt      = lhfc_pkg::MD_WAIT;
          entry_nxt     = now_r;
        end
      end
      lhfc_pkg::MD_NIGHTLIGHT: begin
        window_nxt = '0;
        lamp_nxt   = night_sel;
        mode_nxt   = lhfc_pkg::MD_NIGHTHUM;
        entry_nxt  = now_r;
      end
      lhfc_pkg::MD_NIGHTHUM: begin
        humid_lvl_nxt = night_sel;
        mode_nxt      = lhfc_pkg::MD_WAIT;
        entry_nxt     = now_r;
      end
      lhfc_pkg::MD_WAIT: begin
        if (elapsed >= check_interval_r) begin
          mode_nxt  = lhfc_pkg::MD_CHECK;
          entry_nxt = now_r;
        end
      end
      default: mode_nxt = lhfc_pkg::MD_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= lhfc_pkg::MD_INIT;
      entry_r     <= '0;
      window_r    <= '0;
      lamp_r      <= '0;
      humid_lvl_r <= '0;
    end else if (cmd.commit) begin
      mode_r      <= mode_nxt;
      entry_r     <= entry_nxt;
      window_r    <= window_nxt;
      lamp_r      <= lamp_nxt;
      humid_lvl_r <= humid_lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_window_r <= window_nxt;
      res_lamp_r   <= lamp_nxt;
      res_humid_r  <= humid_lvl_nxt;
      res_state_r  <= mode_nxt;
    end
  end

  assign out_window_pwm     = res_window_r;
  assign out_lamp_pwm       = res_lamp_r;
  assign out_humidifier_pwm = res_humid_r;
  assign out_state_code     = res_state_r;

endmodule

FILE: sv/light_humidity_fsm_controller_core.sv
// ----------------------------------------------------------------------------
// light_humidity_fsm_controller_core: room light and humidity controller
// One input transaction is one pass of an eight-state control loop; each
// pass returns one transaction with the window, lamp and humidifier PWM
// levels and the loop state after the pass.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries the ms timestamp, three 10-bit
//   sensor samples and the alternate-night button. Result channel
//   (out_valid/out_stall) returns one transaction per input transaction.
//   Config port (cfg_we/cfg_index/cfg_wdata) writes one of the eight
//   registers per write; write only while the block is idle.
// Sequence:
//   Each pass is accepted in idle, evaluated, then committed into the
//   result register. A daylight pass that maps inside light also runs
//   the restoring divider, one quotient bit per cycle, after evaluation.
//   The next transaction is taken only after the result is loaded, so a
//   new pass is never accepted before the last one has committed.
// Reset (rst_n low, synchronous): loop goes to init, timer and levels
//   clear, config registers return to their defaults, no result pending.
// Stall: the output register holds a finished result while out_stall is
//   high; one more transaction can be accepted and computed behind it and
//   waits to commit until the output register frees up.
// ----------------------------------------------------------------------------
module light_humidity_fsm_controller_core (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  // input transactions
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_now_ms,
  input  logic [9:0]  in_light_inside,
  input  logic [9:0]  in_light_outside,
  input  logic [9:0]  in_humidity_sample,
  input  logic        in_alt_button,
  // result transactions
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_window_pwm,
  output logic [7:0]  out_lamp_pwm,
  output logic [7:0]  out_humidifier_pwm,
  output logic [2:0]  out_state_code
);

  // sequencer -> datapath commands, datapath -> sequencer status
  lhfc_pkg::lhfc_cmd_t cmd;
  lhfc_pkg::lhfc_sts_t sts;

  lhfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath owns all loop state; besides cfg_we writes it only moves on cmd.capture
  // (sample latch), cmd.div_start (map division, which then runs to its end) and cmd.commit.
  lhfc_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_now_ms          (in_now_ms),
    .in_light_inside    (in_light_inside),
    .in_light_outside   (in_light_outside),
    .in_humidity_sample (in_humidity_sample),
    .in_alt_button      (in_alt_button),
    .cmd                (cmd),
    .sts                (sts),
    .out_window_pwm     (out_window_pwm),
    .out_lamp_pwm       (out_lamp_pwm),
    .out_humidifier_pwm (out_humidifier_pwm),
    .out_state_code     (out_state_code)
  );

endmodule

FILE: sv/lhfc_checker.sv
// ----------------------------------------------------------------------------
// lhfc_checker: port-level checks
// Watches the top-level ports over time; bound to the core below.
// ----------------------------------------------------------------------------
module lhfc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_window_pwm,
  input logic [7:0] out_lamp_pwm,
  input logic [7:0] out_humidifier_pwm,
  input logic [2:0] out_state_code
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a held result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_window_pwm) && $stable(out_lamp_pwm)
      && $stable(out_humidifier_pwm) && $stable(out_state_code))
    else $error("result payload changed while stalled");

  // one transaction in flight: an accept closes the input side next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction accepted back to back");

  // every pass leaves init, so a result never reports it
  a_no_init_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_state_code != lhfc_pkg::MD_INIT)
    else $error("result reports init state");

endmodule

bind light_humidity_fsm_controller_core lhfc_checker u_lhfc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_window_pwm     (out_window_pwm),
  .out_lamp_pwm       (out_lamp_pwm),
  .out_humidifier_pwm (out_humidifier_pwm),
  .out_state_code     (out_state_code)
);

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: light/humidity controller regression
// Drives control-loop passes through the valid/stall input channel, tracks
// the eight-state loop, timer and PWM levels in a local predictor and checks
// every result transaction in order. A short directed sweep comes first,
// then randomized passes under several register settings, extremes included.
// ----------------------------------------------------------------------------
module tb;

  // Longest quiet stretch is the forced receiver hold; the limit is several
  // times that plus a mapped (divider) pass and a config/settle window.
  localparam int HOLD_CYCLES    = 250;
  localparam int SETTLE_CYCLES  = 30;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 150;

  typedef struct {
    logic [31:0] now_ms;
    logic [9:0]  indoor;
    logic [9:0]  outside;
    logic [9:0]  humidity;
    logic        alt;
  } sample_t;

  typedef struct {
    logic [7:0]           window;
    logic [7:0]           lamp;
    logic [7:0]           humid;
    lhfc_pkg::lhfc_mode_t mode;
  } levels_t;

  typedef struct {
    logic [9:0]  day_thr;
    logic [9:0]  light_min;
    logic [9:0]  light_max;
    logic [9:0]  hum_min;
    logic [31:0] humidify_ms;
    logic [31:0] check_ms;
    logic [7:0]  night;
    logic [7:0]  night_alt;
  } regs_t;

  // One directed step; typed rows carry a hand-written expectation
  typedef struct {
    sample_t s;
    bit      typed;
    levels_t lv;
  } step_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_now_ms;
  logic [9:0]  in_light_inside;
  logic [9:0]  in_light_outside;
  logic [9:0]  in_humidity_sample;
  logic        in_alt_button;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_window_pwm;
  logic [7:0]  out_lamp_pwm;
  logic [7:0]  out_humidifier_pwm;
  logic [2:0]  out_state_code;

  light_humidity_fsm_controller_core u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_now_ms          (in_now_ms),
    .in_light_inside    (in_light_inside),
    .in_light_outside   (in_light_outside),
    .in_humidity_sample (in_humidity_sample),
    .in_alt_button      (in_alt_button),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_window_pwm     (out_window_pwm),
    .out_lamp_pwm       (out_lamp_pwm),
    .out_humidifier_pwm (out_humidifier_pwm),
    .out_state_code     (out_state_code)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Local copy of the control loop and its registers
  lhfc_pkg::lhfc_mode_t loop_mode;
  logic [31:0] loop_entry_ms;
  logic [7:0]  window_lvl;
  logic [7:0]  lamp_lvl;
  logic [7:0]  humid_lvl;
  regs_t       regs;

  levels_t     levels_due[$];   // expected result transactions, oldest first
  step_row_t   plan_a[$];
  step_row_t   plan_b[$];
  logic [31:0] last_ms;
  int          mismatch_count;
  int          idle_cycles;
  bit          quiet;           // no idling on either side
  bit          hold_pending;    // asks the receiver for one long hold

  // One pass of the loop: at most one transition, levels held otherwise
  function automatic levels_t advance_loop(sample_t s);
    logic [31:0]  elapsed;
    logic [7:0]   night_pick;
    int unsigned  num;
    int unsigned  den;
    levels_t      r;
    elapsed    = s.now_ms - loop_entry_ms;   // modulo 2^32
    night_pick = s.alt ? regs.night_alt : regs.night;
    case (loop_mode)
      lhfc_pkg::MD_INIT: begin
        loop_mode     = lhfc_pkg::MD_CHECK;
        loop_entry_ms = s.now_ms;
      end
      lhfc_pkg::MD_CHECK: begin
        loop_mode     = (s.outside > regs.day_thr) ? lhfc_pkg::MD_DAYLIGHT
                                                   : lhfc_pkg::MD_NIGHTLIGHT;
        loop_entry_ms = s.now_ms;
      end
      lhfc_pkg::MD_DAYLIGHT: begin
        // bright test wins when both ranges overlap
        if (s.indoor > regs.light_max) begin
          num        = 32'(s.indoor) - 32'(regs.light_max);
          den        = 32'(lhfc_pkg::SENSOR_FULL) - 32'(regs.light_max);
          window_lvl = 8'(32'(lhfc_pkg::BRIGHT_BASE) +
                          (num * 32'(lhfc_pkg::MAP_SLOPE)) / den);
          lamp_lvl   = 8'd0;
        end else if (s.indoor < regs.light_min) begin
          num        = 32'(s.indoor) * 32'(lhfc_pkg::MAP_SLOPE);
          lamp_lvl   = 8'(32'(lhfc_pkg::LEVEL_FULL) - num / 32'(regs.light_min));
          window_lvl = 8'd0;
        end else begin
          window_lvl = 8'd0;
          lamp_lvl   = 8'd0;
        end
        loop_mode     = lhfc_pkg::MD_DAYHUM;
        loop_entry_ms = s.now_ms;
      end
      lhfc_pkg::MD_DAYHUM: begin
        // humidity fine: humidifier level left alone
        if (s.humidity < regs.hum_min) begin
          humid_lvl = lhfc_pkg::LEVEL_FULL;
          loop_mode = lhfc_pkg::MD_HUMON;
        end else begin
          loop_mode = lhfc_pkg::MD_WAIT;
        end
        loop_entry_ms = s.now_ms;
      end
      lhfc_pkg::MD_HUMON: begin
        if (elapsed >= regs.humidify_ms) begin
          humid_lvl     = 8'd0;
          loop_mode     = lhfc_pkg::MD_WAIT;
          loop_entry_ms = s.now_ms;
        end
      end
      lhfc_pkg::MD_NIGHTLIGHT: begin
        window_lvl    = 8'd0;
        lamp_lvl      = night_pick;
        loop_mode     = lhfc_pkg::MD_NIGHTHUM;
        loop_entry_ms = s.now_ms;
      end
      lhfc_pkg::MD_NIGHTHUM: begin
        humid_lvl     = night_pick;
        loop_mode     = lhfc_pkg::MD_WAIT;
        loop_entry_ms = s.now_ms;
      end
      default: begin
        if (elapsed >= regs.check_ms) begin
          loop_mode     = lhfc_pkg::MD_CHECK;
          loop_entry_ms = s.now_ms;
        end
      end
    endcase
    r.window = window_lvl;
    r.lamp   = lamp_lvl;
    r.humid  = humid_lvl;
    r.mode   = loop_mode;
    return r;
  endfunction

  function automatic step_row_t mk_row(logic [31:0] now, logic [9:0] li, logic [9:0] lo,
                                       logic [9:0] hu, logic alt, bit typed,
                                       logic [7:0] w, logic [7:0] l, logic [7:0] h,
                                       lhfc_pkg::lhfc_mode_t m);
    step_row_t r;
    r.s.now_ms   = now;
    r.s.indoor   = li;
    r.s.outside  = lo;
    r.s.humidity = hu;
    r.s.alt      = alt;
    r.typed      = typed;
    r.lv.window  = w;
    r.lv.lamp    = l;
    r.lv.humid   = h;
    r.lv.mode    = m;
    return r;
  endfunction

  // Sample within +/-2 of a threshold, clamped to the converter range
  function automatic logic [9:0] near(logic [9:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 4)) - 2;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return 10'(v);
  endfunction

  function automatic logic [9:0] extreme();
    return ($urandom_range(0, 1) != 0) ? lhfc_pkg::SENSOR_FULL : 10'd0;
  endfunction

  // Timestamps land on either side of the running timer's limit in three of
  // ten draws, so the humidifier run and the wait state both exit and hold.
  function automatic sample_t rand_sample();
    sample_t     s;
    logic [31:0] span;
    span = (loop_mode == lhfc_pkg::MD_HUMON) ? regs.humidify_ms :
           (loop_mode == lhfc_pkg::MD_WAIT)  ? regs.check_ms : 32'd0;
    case ($urandom_range(0, 9))
      0, 1, 2: s.now_ms = loop_entry_ms + span - 32'd1 + 32'($urandom_range(0, 2));
      3:       s.now_ms = $urandom;
      default: s.now_ms = last_ms + 32'($urandom_range(0, 1500));
    endcase
    case ($urandom_range(0, 5))
      0:       s.indoor = near(regs.light_min);
      1:       s.indoor = near(regs.light_max);
      2:       s.indoor = extreme();
      default: s.indoor = 10'($urandom_range(0, 1023));
    endcase
    case ($urandom_range(0, 3))
      0:       s.outside = near(regs.day_thr);
      1:       s.outside = extreme();
      default: s.outside = 10'($urandom_range(0, 1023));
    endcase
    case ($urandom_range(0, 3))
      0:       s.humidity = near(regs.hum_min);
      1:       s.humidity = extreme();
      default: s.humidity = 10'($urandom_range(0, 1023));
    endcase
    s.alt = 1'($urandom_range(0, 1));
    return s;
  endfunction

  function automatic regs_t rand_regs();
    regs_t c;
    c.day_thr     = 10'($urandom_range(0, 1023));
    c.light_min   = 10'($urandom_range(1, 1023));
    c.light_max   = 10'($urandom_range(0, 1022));
    c.hum_min     = 10'($urandom_range(0, 1023));
    c.humidify_ms = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3000);
    c.check_ms    = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3000);
    c.night       = 8'($urandom_range(0, 255));
    c.night_alt   = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [31:0] reg_value(regs_t c, logic [2:0] idx);
    case (idx)
      lhfc_pkg::CFG_DAY_THRESHOLD:   return 32'(c.day_thr);
      lhfc_pkg::CFG_LIGHT_MIN:       return 32'(c.light_min);
      lhfc_pkg::CFG_LIGHT_MAX:       return 32'(c.light_max);
      lhfc_pkg::CFG_HUMIDITY_MIN:    return 32'(c.hum_min);
      lhfc_pkg::CFG_HUMIDIFY_MS:     return c.humidify_ms;
      lhfc_pkg::CFG_CHECK_INTERVAL:  return c.check_ms;
      lhfc_pkg::CFG_NIGHT_LEVEL:     return 32'(c.night);
      lhfc_pkg::CFG_NIGHT_LEVEL_ALT: return 32'(c.night_alt);
      default:                       return 32'd0;
    endcase
  endfunction

  // Writes all eight registers back to back; block must be idle
  task automatic apply_regs(regs_t c);
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_wdata <= reg_value(c, 3'(i));
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    regs = c;
  endtask

  // Offers one transaction, holds it until accepted, records the expectation
  // and sometimes idles the sender afterwards.
  task automatic issue(step_row_t r);
    levels_t pred;
    in_valid           <= 1'b1;
    in_now_ms          <= r.s.now_ms;
    in_light_inside    <= r.s.indoor;
    in_light_outside   <= r.s.outside;
    in_humidity_sample <= r.s.humidity;
    in_alt_button      <= r.s.alt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred    = advance_loop(r.s);
    last_ms = r.s.now_ms;
    if (r.typed) levels_due.push_back(r.lv);
    else levels_due.push_back(pred);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic run_random(int n, int hold_at);
    step_row_t r;
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_pending = 1'b1;
      r.s     = rand_sample();
      r.typed = 1'b0;
      issue(r);
    end
    in_valid <= 1'b0;
  endtask

  // Waits for every outstanding result, then lets the block go quiet
  task automatic settle();
    while (levels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // Result monitor: every accepted result is matched to the oldest expectation
  always @(posedge clk) begin : result_check
    levels_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (levels_due.size() == 0) begin
        $error("result transaction with nothing expected");
        mismatch_count++;
      end else begin
        due = levels_due.pop_front();
        check_field("window_pwm", due.window, out_window_pwm);
        check_field("lamp_pwm", due.lamp, out_lamp_pwm);
        check_field("humidifier_pwm", due.humid, out_humidifier_pwm);
        check_field("state_code", due.mode, out_state_code);
      end
    end
  end

  // Receiver: random stall bursts, one long hold on request, none when quiet.
  // Every assignment is followed by at least one edge.
  initial begin : receiver
    int n;
    out_stall = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall <= 1'b1;
        n = HOLD_CYCLES;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 13);
      end else begin
        out_stall <= 1'b0;
        n = quiet ? 1 : $urandom_range(1, 20);
      end
      repeat (n) @(posedge clk);
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    regs_t c;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = lhfc_pkg::CFG_DAY_THRESHOLD;
    cfg_wdata          = 32'd0;
    in_valid           = 1'b0;
    in_now_ms          = 32'd0;
    in_light_inside    = 10'd0;
    in_light_outside   = 10'd0;
    in_humidity_sample = 10'd0;
    in_alt_button      = 1'b0;
    quiet              = 1'b0;
    hold_pending       = 1'b0;
    mismatch_count     = 0;
    idle_cycles        = 0;
    last_ms            = 32'd0;
    loop_mode          = lhfc_pkg::MD_INIT;
    loop_entry_ms      = 32'd0;
    window_lvl         = 8'd0;
    lamp_lvl           = 8'd0;
    humid_lvl          = 8'd0;
    regs.day_thr       = lhfc_pkg::RST_DAY_THRESHOLD;
    regs.light_min     = lhfc_pkg::RST_LIGHT_MIN;
    regs.light_max     = lhfc_pkg::RST_LIGHT_MAX;
    regs.hum_min       = lhfc_pkg::RST_HUMIDITY_MIN;
    regs.humidify_ms   = lhfc_pkg::RST_HUMIDIFY_MS;
    regs.check_ms      = lhfc_pkg::RST_CHECK_INTERVAL;
    regs.night         = lhfc_pkg::RST_NIGHT_LEVEL;
    regs.night_alt     = lhfc_pkg::RST_NIGHT_LEVEL_ALT;

    // Directed sweep at reset registers: day path with both map extremes,
    // humidifier run on both sides of its limit, wait on both sides, night
    // path with the button, timer wrap, and a mapped value just past max.
    plan_a.push_back(mk_row(32'd0, 0, 0, 0, 0, 1, 0, 0, 0, lhfc_pkg::MD_CHECK));
    plan_a.push_back(mk_row(32'd10, 0, 1023, 0, 0, 1, 0, 0, 0, lhfc_pkg::MD_DAYLIGHT));
    plan_a.push_back(mk_row(32'd20, 1023, 0, 0, 0, 1, 255, 0, 0, lhfc_pkg::MD_DAYHUM));
    plan_a.push_back(mk_row(32'd30, 0, 0, 0, 0, 1, 255, 0, 255, lhfc_pkg::MD_HUMON));
    plan_a.push_back(mk_row(32'd5029, 0, 0, 0, 0, 1, 255, 0, 255, lhfc_pkg::MD_HUMON));
    plan_a.push_back(mk_row(32'd5030, 0, 0, 0, 0, 1, 255, 0, 0, lhfc_pkg::MD_WAIT));
    plan_a.push_back(mk_row(32'd15029, 0, 0, 0, 0, 1, 255, 0, 0, lhfc_pkg::MD_WAIT));
    plan_a.push_back(mk_row(32'd15030, 0, 0, 0, 0, 1, 255, 0, 0, lhfc_pkg::MD_CHECK));
    // outside equal to the threshold is night
    plan_a.push_back(mk_row(32'd15040, 0, 400, 0, 0, 1, 255, 0, 0,
                            lhfc_pkg::MD_NIGHTLIGHT));
    plan_a.push_back(mk_row(32'd15050, 0, 0, 0, 1, 1, 0, 200, 0, lhfc_pkg::MD_NIGHTHUM));
    plan_a.push_back(mk_row(32'd15060, 0, 0, 0, 0, 1, 0, 200, 120, lhfc_pkg::MD_WAIT));
    plan_a.push_back(mk_row(32'hFFFF_F000, 0, 0, 0, 0, 0, 0, 0, 0, lhfc_pkg::MD_INIT));
    plan_a.push_back(mk_row(32'hFFFF_F100, 0, 401, 0, 0, 0, 0, 0, 0, lhfc_pkg::MD_INIT));
    plan_a.push_back(mk_row(32'hFFFF_F200, 0, 0, 0, 0, 1, 0, 255, 120,
                            lhfc_pkg::MD_DAYHUM));
    // humidity at the minimum is fine: humidifier keeps its night level
    plan_a.push_back(mk_row(32'hFFFF_F300, 0, 0, 400, 0, 0, 0, 0, 0, lhfc_pkg::MD_INIT));
    // wait across the 2^32 wrap: one short of the interval, then exactly it
    plan_a.push_back(mk_row(32'h0000_1A0F, 0, 0, 0, 0, 0, 0, 0, 0, lhfc_pkg::MD_INIT));
    plan_a.push_back(mk_row(32'h0000_1A10, 0, 0, 0, 0, 0, 0, 0, 0, lhfc_pkg::MD_INIT));
    plan_a.push_back(mk_row(32'h0000_1A20, 0, 1023, 0, 0, 0, 0, 0, 0, lhfc_pkg::MD_INIT));
    plan_a.push_back(mk_row(32'h0000_1A30, 701, 0, 0, 0, 0, 0, 0, 0, lhfc_pkg::MD_INIT));
    plan_a.push_back(mk_row(32'h0000_1A40, 0, 0, 399, 1, 0, 0, 0, 0, lhfc_pkg::MD_INIT));
    plan_a.push_back(mk_row(32'h0000_1A40 + 32'd5000, 0, 0, 0, 0, 0, 0, 0, 0,
                            lhfc_pkg::MD_INIT));

    // Overlapping light ranges, zero timers: bright test must win
    plan_b.push_back(mk_row(32'd11730, 0, 0, 0, 0, 0, 0, 0, 0, lhfc_pkg::MD_INIT));
    plan_b.push_back(mk_row(32'd11740, 0, 1, 0, 0, 0, 0, 0, 0, lhfc_pkg::MD_INIT));
    plan_b.push_back(mk_row(32'd11750, 1, 0, 0, 0, 0, 0, 0, 0, lhfc_pkg::MD_INIT));
    plan_b.push_back(mk_row(32'd11760, 0, 0, 1022, 1, 0, 0, 0, 0, lhfc_pkg::MD_INIT));
    plan_b.push_back(mk_row(32'd11760, 0, 0, 0, 0, 0, 0, 0, 0, lhfc_pkg::MD_INIT));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan_a[i]) issue(plan_a[i]);
    in_valid <= 1'b0;
    settle();

    // Low extremes, light_min above light_max
    c.day_thr     = 10'd0;
    c.light_min   = lhfc_pkg::SENSOR_FULL;
    c.light_max   = 10'd0;
    c.hum_min     = lhfc_pkg::SENSOR_FULL;
    c.humidify_ms = 32'd0;
    c.check_ms    = 32'd0;
    c.night       = 8'd0;
    c.night_alt   = lhfc_pkg::LEVEL_FULL;
    apply_regs(c);
    foreach (plan_b[i]) issue(plan_b[i]);
    run_random(PHASE_ITEMS, -1);
    settle();

    // High extremes: always night, timers at their longest
    c.day_thr     = lhfc_pkg::SENSOR_FULL;
    c.light_min   = 10'd1;
    c.light_max   = lhfc_pkg::SENSOR_FULL - 10'd1;
    c.hum_min     = 10'd0;
    c.humidify_ms = 32'hFFFF_FFFF;
    c.check_ms    = 32'hFFFF_FFFF;
    c.night       = lhfc_pkg::LEVEL_FULL;
    c.night_alt   = 8'd0;
    apply_regs(c);
    run_random(PHASE_ITEMS, -1);
    settle();

    // Default registers again, with one long receiver hold mid-phase
    c.day_thr     = lhfc_pkg::RST_DAY_THRESHOLD;
    c.light_min   = lhfc_pkg::RST_LIGHT_MIN;
    c.light_max   = lhfc_pkg::RST_LIGHT_MAX;
    c.hum_min     = lhfc_pkg::RST_HUMIDITY_MIN;
    c.humidify_ms = lhfc_pkg::RST_HUMIDIFY_MS;
    c.check_ms    = lhfc_pkg::RST_CHECK_INTERVAL;
    c.night       = lhfc_pkg::RST_NIGHT_LEVEL;
    c.night_alt   = lhfc_pkg::RST_NIGHT_LEVEL_ALT;
    apply_regs(c);
    run_random(PHASE_ITEMS, 30);
    settle();

    for (int p = 0; p < 3; p++) begin
      apply_regs(rand_regs());
      run_random(PHASE_ITEMS, -1);
      settle();
    end

    // Final stretch at full rate, no idling on either side
    quiet = 1'b1;
    apply_regs(rand_regs());
    run_random(PHASE_ITEMS, -1);
    settle();

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
